[rtl/icymd_pkg.sv]
// Package of shared constants, types and tables for the metadata deframer.
package icymd_pkg;

  localparam int unsigned StoreDepth    = 4096;
  localparam int unsigned AddrWidth     = $clog2(StoreDepth);
  localparam int unsigned IntervalWidth = 16;
  localparam int unsigned CfgWidth      = 16;
  localparam int unsigned PosWidth      = 13;
  localparam int unsigned PrefixLen     = 12;
  localparam int unsigned InitLen       = 17;

  typedef logic [AddrWidth-1:0] addr_t;

  typedef enum logic [2:0] {
    StAudio     = 3'd0,
    StAbsorbed  = 3'd1,
    StUnchanged = 3'd2,
    StNewTitle  = 3'd3,
    StBadFormat = 3'd4,
    StHalted    = 3'd5
  } status_kind_e;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } rd_req_t;

  typedef struct packed {
    logic       en;
    addr_t      addr;
    logic [7:0] data;
  } wr_req_t;

  localparam logic [7:0] TitlePrefix [PrefixLen] = '{
    8'h53, 8'h74, 8'h72, 8'h65, 8'h61, 8'h6d, 8'h54, 8'h69, 8'h74, 8'h6c, 8'h65, 8'h3d
  };

  localparam logic [7:0] InitTitle [InitLen] = '{
    8'h01, 8'h53, 8'h74, 8'h72, 8'h65, 8'h61, 8'h6d, 8'h54, 8'h69, 8'h74, 8'h6c,
    8'h65, 8'h3d, 8'h27, 8'h27, 8'h3b, 8'h00
  };

  // Content of a store entry that has not been written since reset.
  function automatic logic [7:0] init_byte(addr_t addr);
    logic [7:0] res;
    res = 8'h00;
    if (addr < AddrWidth'(InitLen)) begin
      res = InitTitle[addr[4:0]];
    end
    return res;
  endfunction

  function automatic logic [7:0] prefix_byte(logic [3:0] idx);
    logic [7:0] res;
    res = 8'h00;
    if (idx < 4'(PrefixLen)) begin
      res = TitlePrefix[idx];
    end
    return res;
  endfunction

endpackage

[rtl/icy_metadata_deframer.sv]
// An accepted transaction is held in the decode register, then in the output register.
// Throughput: one byte per cycle unless the output stalls; one store read and write per cycle.
// The first stage decodes the byte and reads the store, the second compares and writes back.
// Reset clears all control state at once; the title store needs no clearing pass, since
// a fill mark makes unwritten entries read as the empty initial title.
module icy_metadata_deframer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [icymd_pkg::CfgWidth-1:0] cfg_meta_interval_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     status_kind_o,
  output logic [7:0]                     audio_byte_o
);
  import icymd_pkg::*;

  typedef struct packed {
    logic                is_meta;
    logic [7:0]          data;
    logic [PosWidth-1:0] pos;
    logic                last;
  } s1_t;

  logic [IntervalWidth-1:0] interval_q;
  logic [IntervalWidth-1:0] count_q, count_d;
  logic [PosWidth-1:0]      blen_q, blen_d;
  logic [PosWidth-1:0]      bpos_q, bpos_d;
  logic                     halted_q, halted_d;
  logic                     equal_q, equal_d;
  logic                     done_q, done_d;
  logic                     pfx_q, pfx_d;
  logic                     s1_valid_q;
  s1_t                      s1_q, s1_d;
  logic                     out_valid_q;
  status_kind_e             kind_q, kind_d;
  logic [7:0]               audio_q, audio_d;

  logic                advance, accept, s1_fire;
  logic                is_audio;
  logic [PosWidth-1:0] len, pos;
  logic                last;
  logic [7:0]          stored;
  rd_req_t             rd_req;
  wr_req_t             wr_req;

  assign cfg_ready_o = 1'b1;
  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !advance;
  assign accept      = in_valid_i && advance;
  assign s1_fire     = s1_valid_q && advance;

  // Decode stage.
  always_comb begin
    is_audio = (interval_q == '0) || (count_q < interval_q);
    if (blen_q == '0) begin
      len = PosWidth'({data_byte_i, 4'b0000}) + PosWidth'(1);
      pos = '0;
    end else begin
      len = blen_q;
      pos = bpos_q;
    end
    last = ({1'b0, pos} + (PosWidth+1)'(1)) >= {1'b0, len};

    count_d = count_q;
    blen_d  = blen_q;
    bpos_d  = bpos_q;
    if (accept && interval_q != '0) begin
      if (is_audio) begin
        count_d = count_q + IntervalWidth'(1);
      end else if (last) begin
        count_d = '0;
        blen_d  = '0;
        bpos_d  = '0;
      end else begin
        blen_d = len;
        bpos_d = pos + PosWidth'(1);
      end
    end

    s1_d.is_meta = !is_audio;
    s1_d.data    = (!is_audio && last) ? 8'h00 : data_byte_i;
    s1_d.pos     = pos;
    s1_d.last    = last;

    rd_req.en   = accept;
    rd_req.addr = pos[AddrWidth-1:0];
  end

  // Compare and write-back stage.
  always_comb begin
    equal_d  = equal_q;
    done_d   = done_q;
    pfx_d    = pfx_q;
    halted_d = halted_q;
    kind_d   = StAbsorbed;
    audio_d  = 8'h00;
    wr_req.en   = 1'b0;
    wr_req.addr = s1_q.pos[AddrWidth-1:0];
    wr_req.data = s1_q.data;

    if (halted_q) begin
      kind_d = StHalted;
    end else if (!s1_q.is_meta) begin
      kind_d  = StAudio;
      audio_d = s1_q.data;
    end else begin
      if (s1_q.pos == '0) begin
        equal_d = 1'b1;
        done_d  = 1'b0;
        pfx_d   = 1'b1;
      end else begin
        if (!done_q) begin
          if (s1_q.data != stored) begin
            equal_d = 1'b0;
            done_d  = 1'b1;
          end else if (s1_q.data == 8'h00) begin
            done_d = 1'b1;
          end
        end
        if (s1_q.pos <= PosWidth'(PrefixLen) &&
            s1_q.data != prefix_byte(4'(s1_q.pos - PosWidth'(1)))) begin
          pfx_d = 1'b0;
        end
      end
      wr_req.en = s1_fire && !(s1_q.pos == '0 && s1_q.last);
      if (s1_q.last) begin
        if (s1_q.pos != '0 && !equal_d) begin
          if (pfx_d) begin
            kind_d = StNewTitle;
          end else begin
            kind_d   = StBadFormat;
            halted_d = 1'b1;
          end
        end else begin
          kind_d = StUnchanged;
        end
      end
    end
  end

  icymd_title_store u_store (
    .clk_i,
    .rst_ni,
    .rd_i      (rd_req),
    .wr_i      (wr_req),
    .rd_data_o (stored)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= '0;
      count_q     <= '0;
      blen_q      <= '0;
      bpos_q      <= '0;
      halted_q    <= 1'b0;
      equal_q     <= 1'b1;
      done_q      <= 1'b0;
      pfx_q       <= 1'b1;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        interval_q <= IntervalWidth'(cfg_meta_interval_i);
      end
      count_q <= count_d;
      blen_q  <= blen_d;
      bpos_q  <= bpos_d;
      if (advance) begin
        s1_valid_q  <= in_valid_i;
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        halted_q <= halted_d;
        equal_q  <= equal_d;
        done_q   <= done_d;
        pfx_q    <= pfx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s1_fire) begin
      kind_q  <= kind_d;
      audio_q <= audio_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_kind_o = kind_q;
  assign audio_byte_o  = audio_q;

  a_halt_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(halted_q) |-> out_valid_o && status_kind_o == StBadFormat)
    else $error("halt set without a bad-format transaction");

  a_no_write_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_req.en |-> !halted_q)
    else $error("title store written after halt");

  a_audio_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_kind_o != StAudio) |-> audio_byte_o == 8'h00)
    else $error("non-audio transaction carries a byte");

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q && $stable(s1_q))
    else $error("compare stage lost or changed while stalled");

endmodule

[rtl/icymd_title_store.sv]
// Title store: single-port-write memory with registered read, fill mark and forwarding.
module icymd_title_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  icymd_pkg::rd_req_t rd_i,
  input  icymd_pkg::wr_req_t wr_i,
  output logic [7:0]        rd_data_o
);
  import icymd_pkg::*;

  logic [7:0] mem [StoreDepth];
  logic [7:0] mem_q;
  logic [7:0] init_q;
  logic [7:0] fwd_data_q;
  logic       fwd_q;
  logic       filled_q;
  // Blocks are always written from entry zero upwards, so everything below
  // the mark holds written data and everything above it the reset content.
  logic [AddrWidth:0] mark_q, mark_d;
  logic [AddrWidth:0] wr_next;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      mem_q      <= mem[rd_i.addr];
      init_q     <= init_byte(rd_i.addr);
      fwd_data_q <= wr_i.data;
    end
  end

  assign wr_next = {1'b0, wr_i.addr} + (AddrWidth+1)'(1);

  always_comb begin
    mark_d = mark_q;
    if (wr_i.en && wr_next > mark_q) begin
      mark_d = wr_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q   <= '0;
      fwd_q    <= 1'b0;
      filled_q <= 1'b0;
    end else begin
      mark_q <= mark_d;
      if (rd_i.en) begin
        fwd_q    <= wr_i.en && (wr_i.addr == rd_i.addr);
        filled_q <= {1'b0, rd_i.addr} < mark_q;
      end
    end
  end

  always_comb begin
    if (fwd_q) begin
      rd_data_o = fwd_data_q;
    end else if (filled_q) begin
      rd_data_o = mem_q;
    end else begin
      rd_data_o = init_q;
    end
  end

  a_mark_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_q >= $past(mark_q))
    else $error("fill mark went backwards");

  a_mark_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_q <= (AddrWidth+1)'(StoreDepth))
    else $error("fill mark beyond store depth");

  a_write_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.en |-> {1'b0, wr_i.addr} <= mark_q)
    else $error("store write leaves a gap above the fill mark");

endmodule

[tb/sv/tb_icy_metadata_deframer.sv]
// Self-checking testbench for the in-band metadata deframer, predicting every status byte.
`timescale 1ns / 100ps

module tb_icy_metadata_deframer;
  import icymd_pkg::*;

  localparam int unsigned TitleDepth = 4096;

  typedef struct {
    status_kind_e st;
    logic [7:0]   ab;
  } byte_verdict_t;

  typedef struct {
    logic [7:0]   data;
    bit           typed;
    status_kind_e st;
    logic [7:0]   ab;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgWidth-1:0] cfg_meta_interval_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          data_byte_i = 8'h00;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [2:0]          status_kind_o;
  logic [7:0]          audio_byte_o;

  // Shadow of the deframer state.
  logic [15:0]         interval_q;
  logic [15:0]         audio_cnt;
  int unsigned         blk_len;
  int unsigned         blk_pos;
  bit                  still_eq;
  bit                  cmp_done;
  bit                  prefix_good;
  bit                  halted_q;
  logic [7:0]          title_mem [TitleDepth];
  string               title_lead = "StreamTitle=";

  byte_verdict_t       verdict_q [$];
  stim_row_t           rows [$];
  int unsigned         fed_cnt = 0;
  int unsigned         mismatch_cnt = 0;
  bit                  idle_en = 1'b1;
  int unsigned         phase_iv [8] = '{1, 0, 65535, 3, 16, 2, 7, 1};

  icy_metadata_deframer u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_meta_interval_i (cfg_meta_interval_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .data_byte_i         (data_byte_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_kind_o       (status_kind_o),
    .audio_byte_o        (audio_byte_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Works out the status of one stream byte and advances the shadow state.
  function automatic void deframe_byte(input logic [7:0] d, output status_kind_e st,
                                       output logic [7:0] ab);
    int unsigned pos;
    logic [7:0]  b;
    bit          last_byte;
    st = StAudio;
    ab = 8'h00;
    if (halted_q) begin
      st = StHalted;
      return;
    end
    if (interval_q == 16'd0) begin
      ab = d;
      return;
    end
    if (audio_cnt < interval_q) begin
      audio_cnt = audio_cnt + 16'd1;
      ab = d;
      return;
    end
    if (blk_len == 0) begin
      blk_len     = 1 + 16 * int'(d);
      blk_pos     = 0;
      still_eq    = 1'b1;
      cmp_done    = 1'b0;
      prefix_good = 1'b1;
    end
    pos       = blk_pos;
    last_byte = (pos + 1 >= blk_len);
    b         = last_byte ? 8'h00 : d;
    if (pos >= 1) begin
      if (!cmp_done) begin
        if (b != title_mem[pos]) begin
          still_eq = 1'b0;
          cmp_done = 1'b1;
        end else if (b == 8'h00) begin
          cmp_done = 1'b1;
        end
      end
      if (pos <= 12 && b != title_lead[pos-1]) begin
        prefix_good = 1'b0;
      end
    end
    // A one-byte block leaves the store untouched.
    if (!(pos == 0 && last_byte) && pos < TitleDepth) begin
      title_mem[pos] = b;
    end
    if (!last_byte) begin
      blk_pos = pos + 1;
      st = StAbsorbed;
      return;
    end
    if (blk_len > 1 && !still_eq) begin
      if (prefix_good) begin
        st = StNewTitle;
      end else begin
        st = StBadFormat;
        halted_q = 1'b1;
      end
    end else begin
      st = StUnchanged;
    end
    audio_cnt = 16'd0;
    blk_len   = 0;
    blk_pos   = 0;
  endfunction

  task automatic add_row(input logic [7:0] d, input bit typed, input status_kind_e st,
                         input logic [7:0] ab);
    stim_row_t r;
    r.data  = d;
    r.typed = typed;
    r.st    = st;
    r.ab    = ab;
    rows.push_back(r);
  endtask

  // Text of a one-unit block; only its closing byte carries a typed expectation.
  task automatic add_block_text(input string s, input status_kind_e closing);
    for (int i = 0; i < s.len() - 1; i++) begin
      add_row(s[i], 1'b0, StAbsorbed, 8'h00);
    end
    add_row(s[s.len()-1], 1'b1, closing, 8'h00);
  endtask

  task automatic push_stream_byte(input logic [7:0] d, input bit typed = 1'b0,
                                  input status_kind_e st_t = StAudio,
                                  input logic [7:0] ab_t = 8'h00);
    byte_verdict_t v;
    status_kind_e  st;
    logic [7:0]    ab;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    do @(posedge clk_i); while (in_stall_o);
    fed_cnt++;
    deframe_byte(d, st, ab);
    v.st = typed ? st_t : st;
    v.ab = typed ? ab_t : ab;
    verdict_q.push_back(v);
  endtask

  task automatic walk_rows(input int first, input int stop);
    for (int i = first; i < stop; i++) begin
      push_stream_byte(rows[i].data, rows[i].typed, rows[i].st, rows[i].ab);
    end
  endtask

  // Lets every outstanding transaction drain before the register is touched.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_interval(input logic [15:0] v);
    cfg_valid_i         <= 1'b1;
    cfg_meta_interval_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    interval_q = v;
  endtask

  // Audio up to the next block boundary, then one well-formed block. Where the
  // boundary lies more than audio_cap bytes away, only audio is sent.
  task automatic send_frame(input int unsigned audio_cap, input bit huge);
    int unsigned n_audio;
    int unsigned units;
    int unsigned kind;
    bit          ended;
    logic [7:0]  blk [$];
    if (interval_q == 16'd0) begin
      repeat (audio_cap) push_stream_byte(8'($urandom_range(0, 255)));
      return;
    end
    n_audio = (audio_cnt < interval_q) ? int'(interval_q - audio_cnt) : 0;
    if (n_audio > audio_cap) begin
      repeat (audio_cap) push_stream_byte(8'($urandom_range(0, 255)));
      return;
    end
    repeat (n_audio) push_stream_byte(8'($urandom_range(0, 255)));
    kind = huge ? 99 : $urandom_range(0, 9);
    if (kind == 0) begin
      blk.push_back(8'h00);
    end else if (kind < 4) begin
      // Same title again; whatever follows its terminator is not compared.
      units = title_mem[0];
      if (units > 4 || units == 0) units = $urandom_range(1, 2);
      blk.push_back(8'(units));
      ended = 1'b0;
      for (int i = 1; i <= 16 * units; i++) begin
        blk.push_back(ended ? 8'($urandom_range(0, 255)) : title_mem[i]);
        if (title_mem[i] == 8'h00) ended = 1'b1;
      end
    end else begin
      units = huge ? 255 : (kind == 9 ? $urandom_range(3, 6) : $urandom_range(1, 2));
      blk.push_back(8'(units));
      for (int i = 0; i < 12; i++) blk.push_back(title_lead[i]);
      for (int i = 12; i < 16 * units; i++) blk.push_back(8'($urandom_range(0, 255)));
    end
    foreach (blk[i]) push_stream_byte(blk[i]);
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_result
    byte_verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $error("status_kind %0d arrived with no byte outstanding", status_kind_o);
        mismatch_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (status_kind_o !== want.st) begin
          $error("status_kind: expected %0d, got %0d", want.st, status_kind_o);
          mismatch_cnt++;
        end
        if (audio_byte_o !== want.ab) begin
          $error("audio_byte: expected 0x%02h, got 0x%02h", want.ab, audio_byte_o);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned head_end;
    int unsigned stop_at;
    interval_q  = 16'd0;
    audio_cnt   = 16'd0;
    blk_len     = 0;
    blk_pos     = 0;
    still_eq    = 1'b1;
    cmp_done    = 1'b0;
    prefix_good = 1'b1;
    halted_q    = 1'b0;
    foreach (title_mem[i]) title_mem[i] = 8'h00;
    title_mem[0] = 8'h01;
    for (int i = 0; i < 15; i++) title_mem[i+1] = byte'("StreamTitle='';" >> (8 * (14 - i)));

    // Interval zero: extremes pass straight through.
    add_row(8'h00, 1'b1, StAudio, 8'h00);
    add_row(8'hFF, 1'b1, StAudio, 8'hFF);
    add_row(8'h5A, 1'b1, StAudio, 8'h5A);
    // Interval one: an empty block, then a block carrying a new title.
    add_row(8'hA5, 1'b1, StAudio, 8'hA5);
    add_row(8'h00, 1'b1, StUnchanged, 8'h00);
    add_row(8'h3C, 1'b1, StAudio, 8'h3C);
    add_row(8'h01, 1'b1, StAbsorbed, 8'h00);
    add_block_text("StreamTitle='A';", StNewTitle);
    head_end = rows.size();
    // Closing sequence: a block without the prefix halts the stream for good.
    add_row(8'h81, 1'b1, StAudio, 8'h81);
    add_row(8'h01, 1'b1, StAbsorbed, 8'h00);
    add_block_text("Garbage in here!", StBadFormat);
    add_row(8'hFF, 1'b1, StHalted, 8'h00);
    add_row(8'h00, 1'b1, StHalted, 8'h00);
    add_row(8'h77, 1'b1, StHalted, 8'h00);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_interval(16'd0);
    walk_rows(0, 3);
    settle();
    set_interval(16'd1);
    walk_rows(3, head_end);

    // The widest interval is left part way, so the next, lower one starts on a block.
    for (int p = 0; p < 8; p++) begin
      settle();
      idle_en = (p != 7) && ($urandom_range(0, 3) != 0);
      set_interval(16'(phase_iv[p]));
      if (phase_iv[p] == 65535) begin
        send_frame(30, 1'b0);
      end else if (phase_iv[p] == 0) begin
        send_frame(40, 1'b0);
      end else begin
        stop_at = fed_cnt + 50;
        while (fed_cnt < stop_at) send_frame(64, 1'b0);
      end
    end

    settle();
    idle_en = 1'b0;
    set_interval(16'd1);
    walk_rows(head_end, rows.size());
    settle();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
      $display("icy_metadata_deframer regression: pass");
    end else begin
      $display("icy_metadata_deframer regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("icy_metadata_deframer regression: fail");
    $finish;
  end

endmodule

[files.f]
rtl/icymd_pkg.sv
rtl/icymd_title_store.sv
rtl/icy_metadata_deframer.sv
tb/sv/tb_icy_metadata_deframer.sv
